/* rtl/wtbv_pkg.sv */
// wtbv_pkg: shared constants, action codes and cordic arctangent table
// used by the cordic unit and the top level of world_to_body_velocity_command
`default_nettype none
package wtbv_pkg;
    localparam int ANGLE_ITERATIONS = 16;
    localparam int ATAN_LEN = 24;
    localparam int ITER_N = (ANGLE_ITERATIONS < ATAN_LEN) ? ANGLE_ITERATIONS : ATAN_LEN;
    localparam int ITER_W = $clog2(ITER_N + 1);

    localparam logic [1:0] ACT_GOAL = 2'd0;
    localparam logic [1:0] ACT_ODOM = 2'd1;
    localparam logic [1:0] ACT_HEADING = 2'd2;
    localparam logic [1:0] ACT_VEL = 2'd3;

    localparam logic [2:0] REG_MAX_VX = 3'd0;
    localparam logic [2:0] REG_MAX_VY = 3'd1;
    localparam logic [2:0] REG_MAX_TURN = 3'd2;
    localparam logic [2:0] REG_GAIN = 3'd3;
    localparam logic [2:0] REG_STOP = 3'd4;

    localparam logic signed [33:0] PI_Q28 = 34'sd843314857;
    localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;
    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [17:0] PI_Q13 = 18'sd25736;
    localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
    localparam logic [22:0] LIMIT_FLOOR = 23'd655;
    localparam logic [22:0] LIMIT_CEIL = 23'd4194304;

    function automatic logic signed [33:0] atan_q28(input logic [4:0] i);
        case (i)
            5'd0: atan_q28 = 34'sd210828714;
            5'd1: atan_q28 = 34'sd124459457;
            5'd2: atan_q28 = 34'sd65760959;
            5'd3: atan_q28 = 34'sd33381290;
            5'd4: atan_q28 = 34'sd16755422;
            5'd5: atan_q28 = 34'sd8385879;
            5'd6: atan_q28 = 34'sd4193963;
            5'd7: atan_q28 = 34'sd2097109;
            5'd8: atan_q28 = 34'sd1048571;
            5'd9: atan_q28 = 34'sd524287;
            5'd10: atan_q28 = 34'sd262144;
            5'd11: atan_q28 = 34'sd131072;
            5'd12: atan_q28 = 34'sd65536;
            5'd13: atan_q28 = 34'sd32768;
            5'd14: atan_q28 = 34'sd16384;
            5'd15: atan_q28 = 34'sd8192;
            5'd16: atan_q28 = 34'sd4096;
            5'd17: atan_q28 = 34'sd2048;
            5'd18: atan_q28 = 34'sd1024;
            5'd19: atan_q28 = 34'sd512;
            5'd20: atan_q28 = 34'sd256;
            5'd21: atan_q28 = 34'sd128;
            5'd22: atan_q28 = 34'sd64;
            5'd23: atan_q28 = 34'sd32;
            default: atan_q28 = 34'sd0;
        endcase
    endfunction

    // limit register forced into [0.01, 64.0]
    function automatic logic [22:0] eff_limit(input logic [22:0] r);
        if (r < LIMIT_FLOOR) eff_limit = LIMIT_FLOOR;
        else if (r > LIMIT_CEIL) eff_limit = LIMIT_CEIL;
        else eff_limit = r;
    endfunction

    typedef struct packed {
        logic start;
        logic vectoring;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } cordic_cmd_t;
endpackage
`default_nettype wire

/* rtl/wtbv_cordic.sv */
// wtbv_cordic: iterative cordic, one micro-rotation per cycle, vectoring or rotation
// depends on wtbv_pkg
`default_nettype none
module wtbv_cordic (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wtbv_pkg::cordic_cmd_t cmd,
    output logic busy,
    output logic signed [33:0] x_out,
    output logic signed [33:0] y_out,
    output logic signed [33:0] z_out
);
    import wtbv_pkg::*;

    logic signed [33:0] x_reg, y_reg, z_reg;
    logic signed [33:0] x_next, y_next, z_next;
    logic [ITER_W-1:0] iter_reg;
    logic busy_reg;
    logic dir_pos;
    logic signed [33:0] xs, ys, at;

    always_comb
    begin
        // vectoring drives y toward zero, rotation drives z toward zero
        dir_pos = cmd.vectoring ? (y_reg >= 0) : (z_reg >= 0);
        xs = x_reg >>> iter_reg;
        ys = y_reg >>> iter_reg;
        at = atan_q28(5'(iter_reg));
        if (cmd.vectoring == dir_pos)
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + at;
        end
        else
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - at;
        end
        if (cmd.vectoring)
        begin
            if (dir_pos)
            begin
                x_next = x_reg + ys; y_next = y_reg - xs; z_next = z_reg + at;
            end
            else
            begin
                x_next = x_reg - ys; y_next = y_reg + xs; z_next = z_reg - at;
            end
        end
        else
        begin
            if (dir_pos)
            begin
                x_next = x_reg - ys; y_next = y_reg + xs; z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + ys; y_next = y_reg - xs; z_next = z_reg + at;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end
        else if (cmd.start)
        begin
            busy_reg <= (ITER_N != 0);
            iter_reg <= '0;
        end
        else if (busy_reg)
        begin
            iter_reg <= iter_reg + 1'b1;
            if (iter_reg == ITER_W'(ITER_N - 1)) busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            x_reg <= cmd.x;
            y_reg <= cmd.y;
            z_reg <= cmd.z;
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign busy = busy_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule
`default_nettype wire

/* rtl/world_to_body_velocity_command.sv */
// world_to_body_velocity_command: event-driven body-frame velocity and yaw command
// depends on wtbv_pkg and wtbv_cordic
`default_nettype none
// One word is taken at a time; stall on the input stays high until the word is
// done. A goal word is stored and never raises stall. An odometry word
// holds stall through four quaternion products and a setup step, one vectoring
// cordic pass and a store step; a quaternion whose yaw numerator and denominator
// are both zero skips the pass. A heading word adds distance, turn rate and output
// steps. A velocity word skips the quaternion but runs the distance and turn steps,
// one rotation pass and four 33x33 products done one per cycle. The shared cordic
// unit and the single multiplier set these steps. The result sits in an output
// register and is held while the output is stalled; stall on the input stays high
// for as long as the output is stalled.
module world_to_body_velocity_command (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_stall,
    input  wire logic [1:0] action,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [15:0] quat_x,
    input  wire logic signed [15:0] quat_y,
    input  wire logic signed [15:0] quat_z,
    input  wire logic signed [15:0] quat_w,
    input  wire logic signed [31:0] world_vel_x,
    input  wire logic signed [31:0] world_vel_y,
    output logic out_valid,
    input  wire logic out_stall,
    output logic cmd_kind,
    output logic signed [23:0] body_vel_x,
    output logic signed [23:0] body_vel_y,
    output logic signed [15:0] target_yaw,
    output logic signed [23:0] turn_rate,
    input  wire logic cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [30:0] cfg_data
);
    import wtbv_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_Q0 = 5'd1;
    localparam logic [4:0] S_Q1 = 5'd2;
    localparam logic [4:0] S_Q2 = 5'd3;
    localparam logic [4:0] S_Q3 = 5'd4;
    localparam logic [4:0] S_QSET = 5'd5;
    localparam logic [4:0] S_ATAN = 5'd6;
    localparam logic [4:0] S_YAW = 5'd7;
    localparam logic [4:0] S_DX = 5'd8;
    localparam logic [4:0] S_DY = 5'd9;
    localparam logic [4:0] S_RR = 5'd10;
    localparam logic [4:0] S_CMP = 5'd11;
    localparam logic [4:0] S_TURN = 5'd12;
    localparam logic [4:0] S_TURN2 = 5'd13;
    localparam logic [4:0] S_ROT = 5'd14;
    localparam logic [4:0] S_P0 = 5'd15;
    localparam logic [4:0] S_P1 = 5'd16;
    localparam logic [4:0] S_P2 = 5'd17;
    localparam logic [4:0] S_P3 = 5'd18;
    localparam logic [4:0] S_BODY = 5'd19;
    localparam logic [4:0] S_EMIT = 5'd20;
    localparam logic [4:0] S_WAIT = 5'd21;
    localparam logic [4:0] S_CWAIT = 5'd22;

    logic [4:0] state_reg, state_next;

    logic [22:0] max_vx_reg, max_vy_reg, max_turn_reg;
    logic [15:0] gain_reg;
    logic [30:0] stop_reg;

    logic signed [31:0] goal_px_reg, goal_py_reg, robot_px_reg, robot_py_reg;
    logic signed [15:0] robot_yaw_reg, setpoint_reg;
    logic have_goal_reg, have_odom_reg, have_set_reg;

    // latched input word
    logic [1:0] act_reg;
    logic signed [31:0] px_reg, py_reg, vx_reg, vy_reg;
    logic signed [15:0] qx_reg, qy_reg, qz_reg, qw_reg;

    // shared multiplier, operands and registered product
    logic signed [32:0] ma, mb;
    logic signed [65:0] prod_reg;
    logic signed [33:0] acc_reg; // qy squared, denominator finished in S_QSET
    logic signed [33:0] num_reg;
    logic [64:0] dist_reg;
    logic far_reg;
    logic signed [66:0] bx_acc_reg, by_acc_reg;
    logic signed [15:0] yaw_res_reg;
    logic neg_reg;

    logic out_valid_reg, kind_reg;
    logic signed [23:0] bvx_reg, bvy_reg, rate_reg;
    logic signed [15:0] tyaw_reg;

    cordic_cmd_t ccmd;
    logic cbusy;
    logic signed [33:0] cx, cy, cz;

    wtbv_cordic u_cordic (
        .clk(clk), .rst_n(rst_n), .cmd(ccmd), .busy(cbusy),
        .x_out(cx), .y_out(cy), .z_out(cz)
    );

    logic in_acc;
    assign in_acc = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    // yaw from vectoring result, rounded half up and saturated
    logic signed [33:0] zr;
    logic signed [18:0] yaw_w;
    logic signed [15:0] yaw_sat;
    always_comb
    begin
        zr = cz + 34'sd16384;
        yaw_w = 19'(zr >>> 15);
        if (yaw_w > 19'(PI_Q13)) yaw_sat = 16'(PI_Q13);
        else if (yaw_w < -19'(PI_Q13)) yaw_sat = -16'(PI_Q13);
        else yaw_sat = 16'(yaw_w);
    end

    // wrapped yaw error
    logic signed [17:0] err;
    always_comb
    begin
        err = 18'(setpoint_reg) - 18'(robot_yaw_reg);
        if (err >= PI_Q13) err = err - TWO_PI_Q13;
        else if (err < -PI_Q13) err = err + TWO_PI_Q13;
    end

    // rounding and clamping
    logic signed [66:0] rate_w;
    logic signed [24:0] lim_t, lim_x, lim_y;
    logic signed [66:0] bx_r, by_r;
    logic signed [23:0] rate_c, bx_c, by_c;
    always_comb
    begin
        lim_t = 25'(eff_limit(max_turn_reg));
        lim_x = 25'(eff_limit(max_vx_reg));
        lim_y = 25'(eff_limit(max_vy_reg));
        rate_w = (67'(prod_reg) + 67'sd16) >>> 5;
        if (rate_w > 67'(lim_t)) rate_c = 24'(lim_t);
        else if (rate_w < -67'(lim_t)) rate_c = 24'(-lim_t);
        else rate_c = 24'(rate_w);
        bx_r = (bx_acc_reg + (67'sd1 <<< 29)) >>> 30;
        by_r = (by_acc_reg + (67'sd1 <<< 29)) >>> 30;
        if (bx_r > 67'(lim_x)) bx_c = 24'(lim_x);
        else if (bx_r < -67'(lim_x)) bx_c = 24'(-lim_x);
        else bx_c = 24'(bx_r);
        if (by_r > 67'(lim_y)) by_c = 24'(lim_y);
        else if (by_r < -67'(lim_y)) by_c = 24'(-lim_y);
        else by_c = 24'(by_r);
    end

    logic signed [32:0] dxs, dys;
    logic signed [32:0] cosv, sinv;
    always_comb
    begin
        dxs = 33'(robot_px_reg) - 33'(goal_px_reg);
        dys = 33'(robot_py_reg) - 33'(goal_py_reg);
        cosv = neg_reg ? 33'(-cx) : 33'(cx);
        sinv = neg_reg ? 33'(-cy) : 33'(cy);
    end

    // multiplier operand select
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (state_reg)
            S_Q0: begin ma = 33'(qw_reg); mb = 33'(qz_reg); end
            S_Q1: begin ma = 33'(qx_reg); mb = 33'(qy_reg); end
            S_Q2: begin ma = 33'(qy_reg); mb = 33'(qy_reg); end
            S_Q3: begin ma = 33'(qz_reg); mb = 33'(qz_reg); end
            S_DX: begin ma = dxs[32] ? -dxs : dxs; mb = dxs[32] ? -dxs : dxs; end
            S_DY: begin ma = dys[32] ? -dys : dys; mb = dys[32] ? -dys : dys; end
            S_RR: begin ma = 33'(stop_reg); mb = 33'(stop_reg); end
            S_TURN: begin ma = 33'(gain_reg); mb = 33'(err); end
            S_P0: begin ma = cosv; mb = 33'(vx_reg); end
            S_P1: begin ma = sinv; mb = 33'(vy_reg); end
            S_P2: begin ma = cosv; mb = 33'(vy_reg); end
            S_P3: begin ma = sinv; mb = 33'(vx_reg); end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    // denominator 1 - 2(y^2 + z^2); z squared is in the product register in S_QSET
    logic signed [33:0] den_w;
    assign den_w = 34'sd268435456 - ((acc_reg + 34'(prod_reg)) <<< 1);

    always_comb
    begin
        ccmd.start = 1'b0;
        ccmd.vectoring = (act_reg != ACT_VEL);
        ccmd.x = den_w;
        ccmd.y = num_reg;
        ccmd.z = '0;
        if (state_reg == S_QSET)
        begin
            ccmd.start = !(den_w == 0 && num_reg == 0);
            if (den_w < 0)
            begin
                ccmd.x = -den_w;
                ccmd.y = -num_reg;
                ccmd.z = (num_reg >= 0) ? PI_Q28 : -PI_Q28;
            end
        end
        else if (state_reg == S_ROT)
        begin
            ccmd.start = 1'b1;
            ccmd.x = GAIN_Q30;
            ccmd.y = '0;
            ccmd.z = 34'(robot_yaw_reg) <<< 15;
            if (ccmd.z > HALF_PI_Q28) ccmd.z = ccmd.z - PI_Q28;
            else if (ccmd.z < -HALF_PI_Q28) ccmd.z = ccmd.z + PI_Q28;
        end
    end

    logic rot_neg;
    assign rot_neg = (34'(robot_yaw_reg) <<< 15) > HALF_PI_Q28 ||
                     (34'(robot_yaw_reg) <<< 15) < -HALF_PI_Q28;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_acc)
                begin
                    if (action == ACT_GOAL) state_next = S_IDLE;
                    else if (action == ACT_VEL) state_next = S_DX;
                    else state_next = S_Q0;
                end
            S_Q0: state_next = S_Q1;
            S_Q1: state_next = S_Q2;
            S_Q2: state_next = S_Q3;
            S_Q3: state_next = S_QSET;
            S_QSET: state_next = (den_w == 0 && num_reg == 0) ? S_YAW : S_ATAN;
            S_ATAN: state_next = cbusy ? S_ATAN : S_YAW;
            S_YAW: state_next = (act_reg == ACT_ODOM) ? S_IDLE : S_DX;
            S_DX: state_next = S_DY;
            S_DY: state_next = S_RR;
            S_RR: state_next = S_CMP;
            S_CMP: state_next = S_TURN;
            S_TURN: state_next = S_TURN2;
            S_TURN2: state_next = (act_reg == ACT_VEL) ? S_ROT : S_EMIT;
            S_ROT: state_next = S_CWAIT;
            S_CWAIT: state_next = cbusy ? S_CWAIT : S_P0;
            S_P0: state_next = S_P1;
            S_P1: state_next = S_P2;
            S_P2: state_next = S_P3;
            S_P3: state_next = S_BODY;
            S_BODY: state_next = S_EMIT;
            S_EMIT: state_next = S_WAIT;
            S_WAIT: state_next = (out_valid_reg && out_stall) ? S_WAIT : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            max_vx_reg <= 23'd98304;
            max_vy_reg <= 23'd98304;
            max_turn_reg <= 23'd98304;
            gain_reg <= 16'd384;
            stop_reg <= 31'd26214;
            goal_px_reg <= '0;
            goal_py_reg <= '0;
            robot_px_reg <= '0;
            robot_py_reg <= '0;
            robot_yaw_reg <= '0;
            setpoint_reg <= '0;
            have_goal_reg <= 1'b0;
            have_odom_reg <= 1'b0;
            have_set_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAX_VX: max_vx_reg <= cfg_data[22:0];
                    REG_MAX_VY: max_vy_reg <= cfg_data[22:0];
                    REG_MAX_TURN: max_turn_reg <= cfg_data[22:0];
                    REG_GAIN: gain_reg <= cfg_data[15:0];
                    REG_STOP: stop_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (in_acc && action == ACT_GOAL)
            begin
                goal_px_reg <= pos_x;
                goal_py_reg <= pos_y;
                have_goal_reg <= 1'b1;
            end
            if (state_reg == S_YAW)
            begin
                if (act_reg == ACT_ODOM)
                begin
                    robot_px_reg <= px_reg;
                    robot_py_reg <= py_reg;
                    robot_yaw_reg <= yaw_res_reg;
                    have_odom_reg <= 1'b1;
                end
                else
                begin
                    setpoint_reg <= yaw_res_reg;
                    have_set_reg <= 1'b1;
                end
            end
            if (out_valid_reg && !out_stall) out_valid_reg <= 1'b0;
            if (state_reg == S_EMIT) out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= ma * mb;
        if (in_acc)
        begin
            act_reg <= action;
            px_reg <= pos_x;
            py_reg <= pos_y;
            qx_reg <= quat_x;
            qy_reg <= quat_y;
            qz_reg <= quat_z;
            qw_reg <= quat_w;
            vx_reg <= world_vel_x;
            vy_reg <= world_vel_y;
        end
        // products arrive one state after their operands are selected
        case (state_reg)
            S_Q1: num_reg <= 34'(prod_reg);
            S_Q2: num_reg <= (num_reg + 34'(prod_reg)) <<< 1;
            S_Q3: acc_reg <= 34'(prod_reg);
            S_QSET: yaw_res_reg <= '0;
            default: ;
        endcase
        if (state_reg == S_ATAN && !cbusy) yaw_res_reg <= yaw_sat;
        if (state_reg == S_DY) dist_reg <= 65'(prod_reg);
        if (state_reg == S_RR) dist_reg <= dist_reg + 65'(prod_reg);
        // a sum that carries into bit 64 counts as far
        if (state_reg == S_CMP)
            far_reg <= dist_reg[64] || (dist_reg[63:0] > 64'(prod_reg));
        if (state_reg == S_ROT) neg_reg <= rot_neg;
        if (state_reg == S_P1) bx_acc_reg <= 67'(prod_reg);
        if (state_reg == S_P2) bx_acc_reg <= bx_acc_reg + 67'(prod_reg);
        if (state_reg == S_P3) by_acc_reg <= 67'(prod_reg);
        if (state_reg == S_BODY) by_acc_reg <= by_acc_reg - 67'(prod_reg);
        if (state_reg == S_TURN2) rate_reg <= rate_c;
        if (state_reg == S_EMIT)
        begin
            if (act_reg == ACT_HEADING)
            begin
                if (have_goal_reg && have_odom_reg && !far_reg)
                begin
                    kind_reg <= 1'b0; tyaw_reg <= '0; rate_reg <= '0;
                end
                else
                begin
                    kind_reg <= 1'b1; tyaw_reg <= setpoint_reg;
                    if (!have_odom_reg) rate_reg <= '0;
                end
                bvx_reg <= '0; bvy_reg <= '0;
            end
            else if (!have_odom_reg || (have_goal_reg && !far_reg))
            begin
                kind_reg <= 1'b0; bvx_reg <= '0; bvy_reg <= '0;
                tyaw_reg <= '0; rate_reg <= '0;
            end
            else
            begin
                kind_reg <= 1'b1; bvx_reg <= bx_c; bvy_reg <= by_c;
                tyaw_reg <= have_set_reg ? setpoint_reg : 16'sd0;
                if (!have_set_reg) rate_reg <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign cmd_kind = kind_reg;
    assign body_vel_x = bvx_reg;
    assign body_vel_y = bvy_reg;
    assign target_yaw = tyaw_reg;
    assign turn_rate = rate_reg;
endmodule
`default_nettype wire

/* verif/tb_world_to_body_velocity_command.sv */
`timescale 1ns / 1ps
// tb_world_to_body_velocity_command: self-checking bench for world_to_body_velocity_command
// depends on wtbv_pkg and the rtl top level; predicts commands with its own cordic model
module tb_world_to_body_velocity_command;
    import wtbv_pkg::*;

    typedef struct {
        logic [1:0] act;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
    } event_word_t;

    typedef struct {
        logic kind;
        logic signed [23:0] bvx;
        logic signed [23:0] bvy;
        logic signed [15:0] yaw;
        logic signed [23:0] rate;
    } command_t;

    // directed rows; has_fixed marks rows whose command is written in by hand
    typedef struct {
        event_word_t w;
        bit has_fixed;
        command_t fixed;
    } directed_row_t;

    localparam longint ATAN_TBL [24] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
        4193963, 2097109, 1048571, 524287, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048,
        1024, 512, 256, 128, 64, 32};
    localparam longint PI28 = 843314857;
    localparam longint HPI28 = 421657428;
    localparam longint K30 = 652032874;
    localparam longint PI13 = 25736;
    localparam longint TWOPI13 = 51472;
    localparam int CYCLE_LIMIT = 600000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] action = ACT_GOAL;
    logic signed [31:0] pos_x = '0, pos_y = '0;
    logic signed [15:0] quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
    logic signed [31:0] world_vel_x = '0, world_vel_y = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic cmd_kind;
    logic signed [23:0] body_vel_x, body_vel_y, turn_rate;
    logic signed [15:0] target_yaw;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = REG_MAX_VX;
    logic [30:0] cfg_data = '0;

    world_to_body_velocity_command dut (.*);

    always #5 clk = ~clk;

    // predictor state
    longint lim_vx, lim_vy, lim_turn, gain, stop_r;
    longint goal_x, goal_y, bot_x, bot_y, bot_yaw, sp_yaw;
    bit seen_goal, seen_odom, seen_sp;

    command_t pending_cmds[$];
    int errors = 0;
    int cmds_checked = 0;
    int words_sent = 0;
    bit quiet = 1'b0;
    longint cycles = 0;

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint sym_clamp(longint v, longint lim);
        return v > lim ? lim : (v < -lim ? -lim : v);
    endfunction

    function automatic longint bounded_limit(longint r);
        return r < 655 ? 655 : (r > 4194304 ? 4194304 : r);
    endfunction

    function automatic longint quat_heading(event_word_t w);
        longint qx, qy, qz, qw, x, y, z, xo;
        qx = w.qx; qy = w.qy; qz = w.qz; qw = w.qw;
        x = 268435456 - 2 * (qy * qy + qz * qz);
        y = 2 * (qw * qz + qx * qy);
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? PI28 : -PI28;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < ANGLE_ITERATIONS && i < 24; i++) begin
            xo = x;
            if (y >= 0) begin
                x += floor_shr(y, i); y -= floor_shr(xo, i); z += ATAN_TBL[i];
            end
            else begin
                x -= floor_shr(y, i); y += floor_shr(xo, i); z -= ATAN_TBL[i];
            end
        end
        return sym_clamp(floor_shr(z + 16384, 15), PI13);
    endfunction

    function automatic bit within_stop();
        longint unsigned ux, uy, a, b, s, r;
        ux = (bot_x - goal_x) < 0 ? -(bot_x - goal_x) : (bot_x - goal_x);
        uy = (bot_y - goal_y) < 0 ? -(bot_y - goal_y) : (bot_y - goal_y);
        a = ux * ux; b = uy * uy; s = a + b;
        r = stop_r;
        if (s < a) return 1'b0;
        return s <= r * r;
    endfunction

    function automatic longint yaw_rate_cmd();
        longint e;
        e = sp_yaw - bot_yaw;
        if (e >= PI13) e -= TWOPI13;
        else if (e < -PI13) e += TWOPI13;
        return sym_clamp(floor_shr(gain * e + 16, 5), bounded_limit(lim_turn));
    endfunction

    function automatic command_t make_cmd(bit k, longint bx, longint by, longint yw, longint rt);
        command_t c;
        c.kind = k; c.bvx = bx[23:0]; c.bvy = by[23:0]; c.yaw = yw[15:0]; c.rate = rt[23:0];
        return c;
    endfunction

    // advance the predictor by one word; returns 1 with the command when one is due
    function automatic bit predict_command(event_word_t w, output command_t c);
        longint z, x, y, xo, cs, sn, bx, by, vx, vy;
        bit flip;
        c = make_cmd(0, 0, 0, 0, 0);
        case (w.act)
            ACT_GOAL: begin
                goal_x = w.px; goal_y = w.py; seen_goal = 1;
                return 0;
            end
            ACT_ODOM: begin
                bot_x = w.px; bot_y = w.py; bot_yaw = quat_heading(w); seen_odom = 1;
                return 0;
            end
            ACT_HEADING: begin
                sp_yaw = quat_heading(w); seen_sp = 1;
                if (seen_goal && seen_odom && within_stop()) return 1;
                c = make_cmd(1, 0, 0, sp_yaw, seen_odom ? yaw_rate_cmd() : 0);
                return 1;
            end
            default: begin
                if (!seen_odom || (seen_goal && within_stop())) return 1;
                z = bot_yaw * 32768; x = K30; y = 0; flip = 0;
                if (z > HPI28) begin z -= PI28; flip = 1; end
                else if (z < -HPI28) begin z += PI28; flip = 1; end
                for (int i = 0; i < ANGLE_ITERATIONS && i < 24; i++) begin
                    xo = x;
                    if (z >= 0) begin
                        x -= floor_shr(y, i); y += floor_shr(xo, i); z -= ATAN_TBL[i];
                    end
                    else begin
                        x += floor_shr(y, i); y -= floor_shr(xo, i); z += ATAN_TBL[i];
                    end
                end
                cs = flip ? -x : x;
                sn = flip ? -y : y;
                vx = w.vx; vy = w.vy;
                bx = sym_clamp(floor_shr(cs * vx + sn * vy + (64'sd1 << 29), 30),
                               bounded_limit(lim_vx));
                by = sym_clamp(floor_shr(cs * vy - sn * vx + (64'sd1 << 29), 30),
                               bounded_limit(lim_vy));
                if (seen_sp) c = make_cmd(1, bx, by, sp_yaw, yaw_rate_cmd());
                else c = make_cmd(1, bx, by, 0, 0);
                return 1;
            end
        endcase
    endfunction

    task automatic write_reg(logic [2:0] idx, longint val);
        @(posedge clk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val[30:0];
        case (idx)
            REG_MAX_VX: lim_vx = val & 64'h7FFFFF;
            REG_MAX_VY: lim_vy = val & 64'h7FFFFF;
            REG_MAX_TURN: lim_turn = val & 64'h7FFFFF;
            REG_GAIN: gain = val & 64'hFFFF;
            default: stop_r = val & 64'h7FFFFFFF;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // idle point: every expected command back, then cover the no-result word latency
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic send_word(event_word_t w, bit has_fixed = 0, command_t fixed = '{default: 0});
        command_t c;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= w.act; pos_x <= w.px; pos_y <= w.py;
        quat_x <= w.qx; quat_y <= w.qy; quat_z <= w.qz; quat_w <= w.qw;
        world_vel_x <= w.vx; world_vel_y <= w.vy;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (predict_command(w, c)) begin
            if (has_fixed) c = fixed;
            pending_cmds.push_back(c);
        end
        words_sent++;
    endtask

    function automatic event_word_t blank_word(logic [1:0] a);
        event_word_t w;
        w.act = a; w.px = 0; w.py = 0; w.qx = 0; w.qy = 0; w.qz = 0; w.qw = 16384;
        w.vx = 0; w.vy = 0;
        return w;
    endfunction

    function automatic logic signed [15:0] rand_q();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            default: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_wide(int scale);
        case ($urandom_range(0, 7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom();
            default: return $signed($urandom_range(0, 2 * scale)) - scale;
        endcase
    endfunction

    function automatic event_word_t random_word();
        event_word_t w;
        int r;
        r = $urandom_range(0, 9);
        w.act = r < 1 ? ACT_GOAL : (r < 4 ? ACT_ODOM : (r < 6 ? ACT_HEADING : ACT_VEL));
        w.px = rand_wide(200000); w.py = rand_wide(200000);
        w.qx = rand_q(); w.qy = rand_q(); w.qz = rand_q(); w.qw = rand_q();
        w.vx = rand_wide(400000); w.vy = rand_wide(400000);
        return w;
    endfunction

    // response checker
    always @(posedge clk) begin
        command_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_cmds.size() == 0) begin
                $display("%0t: unexpected command kind=%0d", $realtime, cmd_kind);
                errors++;
            end
            else begin
                e = pending_cmds.pop_front();
                cmds_checked++;
                if (cmd_kind !== e.kind) begin
                    $display("%0t: cmd_kind exp %0d got %0d", $realtime, e.kind, cmd_kind);
                    errors++;
                end
                if (body_vel_x !== e.bvx) begin
                    $display("%0t: body_vel_x exp %0d got %0d", $realtime, e.bvx, body_vel_x);
                    errors++;
                end
                if (body_vel_y !== e.bvy) begin
                    $display("%0t: body_vel_y exp %0d got %0d", $realtime, e.bvy, body_vel_y);
                    errors++;
                end
                if (target_yaw !== e.yaw) begin
                    $display("%0t: target_yaw exp %0d got %0d", $realtime, e.yaw, target_yaw);
                    errors++;
                end
                if (turn_rate !== e.rate) begin
                    $display("%0t: turn_rate exp %0d got %0d", $realtime, e.rate, turn_rate);
                    errors++;
                end
            end
        end
    end

    // receiver stall bursts
    initial begin
        forever begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("world_to_body_velocity_command verification failed");
            $finish;
        end
    end

    initial begin
        directed_row_t rows[$];
        directed_row_t d;
        event_word_t w;
        command_t hold;
        hold = make_cmd(0, 0, 0, 0, 0);
        lim_vx = 98304; lim_vy = 98304; lim_turn = 98304; gain = 384; stop_r = 26214;
        goal_x = 0; goal_y = 0; bot_x = 0; bot_y = 0; bot_yaw = 0; sp_yaw = 0;
        seen_goal = 0; seen_odom = 0; seen_sp = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // velocity before odometry holds; heading before odometry has zero rate
        d.has_fixed = 1; d.w = blank_word(ACT_VEL); d.fixed = hold; rows.push_back(d);
        d.w = blank_word(ACT_HEADING); d.fixed = make_cmd(1, 0, 0, 0, 0); rows.push_back(d);
        d.has_fixed = 0;
        // odometry at origin with no goal yet: the stop radius does not apply
        d.w = blank_word(ACT_ODOM); rows.push_back(d);
        d.w = blank_word(ACT_VEL); d.w.vx = 32'sh10000; rows.push_back(d);
        d.w = blank_word(ACT_GOAL); d.w.px = 32'sh7FFFFFFF; d.w.py = 32'sh80000000;
        rows.push_back(d);
        // far goal: velocity and heading both control
        d.w = blank_word(ACT_VEL); d.w.vx = 32'sh7FFFFFFF; d.w.vy = 32'sh80000000;
        rows.push_back(d);
        d.w = blank_word(ACT_GOAL); d.w.px = 32'sh100000; rows.push_back(d);
        // yaw of pi: quaternion z = 1, negative den path
        d.w = blank_word(ACT_ODOM); d.w.qw = 0; d.w.qz = 16'sd16384; rows.push_back(d);
        d.w = blank_word(ACT_VEL); d.w.vx = 32'sh20000; d.w.vy = -32'sh8000; rows.push_back(d);
        d.w = blank_word(ACT_HEADING); d.w.qw = 0; d.w.qz = -16'sd16384; rows.push_back(d);
        // non-unit quaternion with x = y = 1: negative den path, nonzero yaw
        d.w = blank_word(ACT_HEADING); d.w.qw = 0; d.w.qx = 16'sd16384; d.w.qy = 16'sd16384;
        rows.push_back(d);
        d.w = blank_word(ACT_HEADING); d.w.qw = 16'sd11585; d.w.qz = 16'sd11585;
        rows.push_back(d);
        d.w = blank_word(ACT_ODOM); d.w.px = 32'sh80000000; d.w.py = 32'sh7FFFFFFF;
        d.w.qx = -16'sd16384; d.w.qy = -16'sd16384; d.w.qz = -16'sd16384; d.w.qw = -16'sd16384;
        rows.push_back(d);
        d.w = blank_word(ACT_VEL); d.w.vx = 32'sh80000000; d.w.vy = 32'sh7FFFFFFF;
        rows.push_back(d);
        // robot back on the goal: both event kinds hold
        d.w = blank_word(ACT_ODOM); d.w.px = 32'sh100000; rows.push_back(d);
        d.has_fixed = 1; d.fixed = hold;
        d.w = blank_word(ACT_HEADING); rows.push_back(d);
        d.w = blank_word(ACT_VEL); rows.push_back(d);
        foreach (rows[i]) send_word(rows[i].w, rows[i].has_fixed, rows[i].fixed);

        // sender pause until drained, then register extremes
        wait_drained();
        write_reg(REG_MAX_VX, 0); write_reg(REG_MAX_VY, 23'h7FFFFF);
        write_reg(REG_MAX_TURN, 0); write_reg(REG_GAIN, 16'hFFFF);
        write_reg(REG_STOP, 0);
        for (int n = 0; n < 150; n++) send_word(random_word());

        wait_drained();
        write_reg(REG_MAX_VX, 23'h7FFFFF); write_reg(REG_MAX_VY, 655);
        write_reg(REG_MAX_TURN, 23'h7FFFFF); write_reg(REG_GAIN, 0);
        write_reg(REG_STOP, 31'h7FFFFFFF);
        for (int n = 0; n < 100; n++) send_word(random_word());

        wait_drained();
        write_reg(REG_MAX_VX, 4194304); write_reg(REG_MAX_VY, 200000);
        write_reg(REG_MAX_TURN, 4194304); write_reg(REG_GAIN, 2000);
        write_reg(REG_STOP, 300000);
        for (int n = 0; n < 200; n++) send_word(random_word());

        // final stretch with no idling on either side
        quiet = 1'b1;
        for (int n = 0; n < 150; n++) send_word(random_word());
        in_valid <= 1'b0;

        while (pending_cmds.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        $display("covered %0d words and %0d checked commands over four register settings",
                 words_sent, cmds_checked);
        if (errors == 0 && pending_cmds.size() == 0)
            $display("world_to_body_velocity_command verification clean");
        else
            $display("world_to_body_velocity_command verification failed");
        $finish;
    end
endmodule
